// ----- design/grid_maze_generator_macros.svh -----
// Assertion shorthands for the maze generator checker.
`ifndef GRID_MAZE_GENERATOR_MACROS_SVH
`define GRID_MAZE_GENERATOR_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MZG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("maze generator check failed");

// Next-cycle implication, quiet while reset is asserted.
`define MZG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("maze generator check failed");

// Next-cycle implication that also covers the reset cycles.
`define MZG_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("maze generator reset check failed");

`endif

// ----- design/mzg_pkg.sv -----
// ----------------------------------------------------------------------------
// mzg_pkg
// Shared constants, item types and list control for the maze generator.
// ----------------------------------------------------------------------------
package mzg_pkg;

    localparam int GridSize  = 23;
    localparam int WallSlots = 512;

    localparam int CoordW    = 5;
    localparam int EntryW    = 10;
    localparam int RndW      = 15;
    localparam int PendW     = 10;
    localparam int CntW      = $clog2(WallSlots + 1);
    localparam int IdxW      = $clog2(WallSlots);
    localparam int HalfCells = (GridSize - 1) / 2;
    localparam int HalfW     = $clog2(HalfCells);

    localparam int TreeL1 = (WallSlots + 7) / 8;
    localparam int TreeL2 = (TreeL1 + 7) / 8;
    localparam int TreeL3 = (TreeL2 + 7) / 8;

    localparam logic [1:0] CmdInit = 2'd0;
    localparam logic [1:0] CmdStep = 2'd1;
    localparam logic [1:0] CmdRead = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [RndW-1:0]   random_value;
        logic [CoordW-1:0] cell_x;
        logic [CoordW-1:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic             cell_is_wall;
        logic             wall_opened;
        logic [PendW-1:0] walls_pending;
        logic             maze_done;
    } t_out_item;

    typedef struct packed {
        logic              init;
        logic              app;
        logic [IdxW-1:0]   app_addr;
        logic [EntryW-1:0] app_data;
        logic              shift;
        logic [IdxW-1:0]   pos;
    } t_list_ctl;

    function automatic logic [EntryW-1:0] pack_entry(input logic [CoordW-1:0] x,
                                                     input logic [CoordW-1:0] y);
        return {x, y};
    endfunction

endpackage

// ----- design/mzg_cell.sv -----
// ----------------------------------------------------------------------------
// mzg_cell
// One slot of the candidate wall list: load a new entry or take the neighbor's.
// ----------------------------------------------------------------------------
module mzg_cell import mzg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_ld,
    input  logic [EntryW-1:0] i_ld_data,
    input  logic              i_shift,
    input  logic [EntryW-1:0] i_next,
    output logic [EntryW-1:0] o_q
);

    logic [EntryW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_q <= i_ld_data;
        end else if (i_shift) begin
            r_q <= i_next;
        end
    end

    assign o_q = r_q;

endmodule

// ----- design/mzg_list.sv -----
// ----------------------------------------------------------------------------
// mzg_list
// Ordered candidate wall list as a chain of cells, with a registered
// select tree that returns the entry at the chosen position.
// ----------------------------------------------------------------------------
module mzg_list import mzg_pkg::*; (
    input  logic              i_clk,
    input  t_list_ctl         i_ctl,
    output logic [EntryW-1:0] o_entry
);

    logic [EntryW-1:0] w_q   [WallSlots];
    logic [EntryW-1:0] w_sel [TreeL1*8];
    logic [EntryW-1:0] r_l1  [TreeL1];
    logic [EntryW-1:0] r_l2  [TreeL2];
    logic [EntryW-1:0] r_l3  [TreeL3];
    logic [EntryW-1:0] w_or;

    function automatic logic [EntryW-1:0] or_l1(input int g);
        logic [EntryW-1:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (g * 8 + k < TreeL1) begin
                acc = acc | r_l1[g*8+k];
            end
        end
        return acc;
    endfunction

    function automatic logic [EntryW-1:0] or_l2(input int g);
        logic [EntryW-1:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (g * 8 + k < TreeL2) begin
                acc = acc | r_l2[g*8+k];
            end
        end
        return acc;
    endfunction

    for (genvar gi = 0; gi < WallSlots; gi++) begin : g_cell
        logic              w_ld;
        logic [EntryW-1:0] w_ld_data;
        logic [EntryW-1:0] w_next;

        if (gi == 0) begin : g_first
            assign w_ld_data = i_ctl.init ? pack_entry(CoordW'(1), CoordW'(2))
                                          : i_ctl.app_data;
        end else if (gi == 1) begin : g_second
            assign w_ld_data = i_ctl.init ? pack_entry(CoordW'(2), CoordW'(1))
                                          : i_ctl.app_data;
        end else begin : g_rest
            assign w_ld_data = i_ctl.app_data;
        end

        if (gi < 2) begin : g_init
            assign w_ld = i_ctl.init || (i_ctl.app && i_ctl.app_addr == IdxW'(gi));
        end else begin : g_noinit
            assign w_ld = i_ctl.app && i_ctl.app_addr == IdxW'(gi);
        end

        if (gi == WallSlots - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_q[gi+1];
        end

        mzg_cell u_cell (
            .i_clk     (i_clk),
            .i_ld      (w_ld),
            .i_ld_data (w_ld_data),
            .i_shift   (i_ctl.shift && (IdxW'(gi) >= i_ctl.pos)),
            .i_next    (w_next),
            .o_q       (w_q[gi])
        );
    end

    always_comb begin
        for (int i = 0; i < TreeL1 * 8; i++) begin
            if (i < WallSlots && i_ctl.pos == IdxW'(i)) begin
                w_sel[i] = w_q[i];
            end else begin
                w_sel[i] = '0;
            end
        end
    end

    // three registered OR levels, eight wide each
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < TreeL1; g++) begin
            r_l1[g] <= w_sel[g*8]   | w_sel[g*8+1] | w_sel[g*8+2] | w_sel[g*8+3]
                     | w_sel[g*8+4] | w_sel[g*8+5] | w_sel[g*8+6] | w_sel[g*8+7];
        end
        for (int g = 0; g < TreeL2; g++) begin
            r_l2[g] <= or_l1(g);
        end
        for (int g = 0; g < TreeL3; g++) begin
            r_l3[g] <= or_l2(g);
        end
    end

    always_comb begin
        w_or = '0;
        for (int g = 0; g < TreeL3; g++) begin
            w_or = w_or | r_l3[g];
        end
    end

    assign o_entry = w_or;

endmodule

// ----- design/mzg_mod.sv -----
// ----------------------------------------------------------------------------
// mzg_mod
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mzg_mod import mzg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RndW-1:0] i_dividend,
    input  logic [CntW-1:0] i_divisor,
    output logic            o_busy,
    output logic [IdxW-1:0] o_rem
);

    localparam int StepW = $clog2(RndW + 1);

    logic [StepW-1:0] r_left;
    logic [RndW-1:0]  r_num;
    logic [CntW-1:0]  r_den;
    logic [CntW-1:0]  r_rem;
    logic [CntW:0]    w_trial;
    logic [CntW-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[RndW-1]};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = CntW'(w_trial - {1'b0, r_den});
        end else begin
            n_rem = CntW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= StepW'(RndW);
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
        end else if (r_left != '0) begin
            r_left <= r_left - StepW'(1);
            r_num  <= {r_num[RndW-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_left != '0);
    assign o_rem  = r_rem[IdxW-1:0];

endmodule

// ----- design/grid_maze_generator.sv -----
// ----------------------------------------------------------------------------
// grid_maze_generator
// Randomized Prim maze builder: init, step and cell read commands.
//
//   channel | direction | payload     | handshake
//   in      | input     | t_in_item   | i_in_valid / o_in_stall
//   out     | output    | t_out_item  | o_out_valid / i_out_stall
//
// Init, read and unused commands: accept, finishing state, output register.
// Step: the remainder unit (one dividend bit a cycle plus the handoff), a walk
// of the 3-level select tree over the wall list, one or two visited lookups,
// three append slots when a wall opens, one chain shift and the output
// register. A step on an empty list goes straight to the finishing state.
// Reset is synchronous; the grid and visited flags clear at once.
// Input stalls while an item is in work; a result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module grid_maze_generator import mzg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_TREE, ST_CHK, ST_APP, ST_ERASE, ST_FIN
    } t_state;

    localparam logic [CoordW-1:0] GridC = CoordW'(GridSize);
    localparam logic [CoordW-1:0] LastC = CoordW'(GridSize - 1);

    t_state            r_state;
    logic              r_vis    [HalfCells][HalfCells];
    logic              r_open_r [HalfCells][HalfCells];
    logic              r_open_d [HalfCells][HalfCells];
    logic [CntW-1:0]   r_cnt;
    logic              r_started;
    logic [IdxW-1:0]   r_n;
    logic [1:0]        r_t;
    logic [CoordW-1:0] r_wx, r_wy, r_cx, r_cy;
    logic              r_side;
    logic              r_along_y;
    logic              r_wall;
    logic              r_opened;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_accept;
    logic              w_mod_busy;
    logic [IdxW-1:0]   w_mod_rem;
    logic [EntryW-1:0] w_entry;
    t_list_ctl         w_ctl;
    logic              w_out_free;

    // read path
    logic              w_rd_wall;
    logic [CoordW-1:0] w_rx, w_ry;

    // step candidate
    logic [CoordW:0]   w_cx6, w_cy6;
    logic              w_c_ok;
    logic              w_c_vis;
    logic [HalfW-1:0]  w_oi, w_oj;

    // append path
    logic [CoordW-1:0] w_ax, w_ay;
    logic              w_app_ok;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_rx = i_in_item.cell_x;
        w_ry = i_in_item.cell_y;
        if (w_rx >= GridC || w_ry >= GridC) begin
            w_rd_wall = 1'b1;
        end else begin
            case ({w_rx[0], w_ry[0]})
                2'b11:   w_rd_wall = 1'b0;
                2'b00:   w_rd_wall = 1'b1;
                2'b01: begin
                    if (w_rx == '0 || w_rx == LastC) begin
                        w_rd_wall = 1'b1;
                    end else begin
                        w_rd_wall = !r_open_r[w_rx[HalfW:1] - HalfW'(1)][w_ry[HalfW:1]];
                    end
                end
                default: begin
                    if (w_ry == '0 || w_ry == LastC) begin
                        w_rd_wall = 1'b1;
                    end else begin
                        w_rd_wall = !r_open_d[w_rx[HalfW:1]][w_ry[HalfW:1] - HalfW'(1)];
                    end
                end
            endcase
        end
    end

    // cell beside the picked wall: backward side first, then forward
    always_comb begin
        if (r_wx[0]) begin
            w_cx6  = {1'b0, r_wx};
            w_cy6  = r_side ? {1'b0, r_wy} + 1'b1 : {1'b0, r_wy} - 1'b1;
            w_c_ok = r_side ? (w_cy6 < {1'b0, GridC}) : (r_wy != '0);
            w_oi   = r_wx[HalfW:1];
            w_oj   = r_wy[HalfW:1] - HalfW'(1);
        end else begin
            w_cy6  = {1'b0, r_wy};
            w_cx6  = r_side ? {1'b0, r_wx} + 1'b1 : {1'b0, r_wx} - 1'b1;
            w_c_ok = r_side ? (w_cx6 < {1'b0, GridC}) : (r_wx != '0);
            w_oi   = r_wx[HalfW:1] - HalfW'(1);
            w_oj   = r_wy[HalfW:1];
        end
        w_c_ok  = w_c_ok && (r_wx < GridC) && (r_wy < GridC);
        w_c_vis = r_vis[w_cx6[HalfW:1]][w_cy6[HalfW:1]];
    end

    always_comb begin
        w_ax = r_cx;
        w_ay = r_cy;
        case (r_t)
            2'd0: begin
                if (r_along_y) w_ax = r_cx - CoordW'(1);
                else           w_ay = r_cy - CoordW'(1);
            end
            2'd1: begin
                if (r_along_y) w_ax = r_cx + CoordW'(1);
                else           w_ay = r_cy + CoordW'(1);
            end
            default: begin
                if (r_along_y) w_ay = r_side ? r_cy + CoordW'(1) : r_cy - CoordW'(1);
                else           w_ax = r_side ? r_cx + CoordW'(1) : r_cx - CoordW'(1);
            end
        endcase
        w_app_ok = (w_ax != '0) && (w_ay != '0) && (w_ax < LastC) && (w_ay < LastC)
                && (r_cnt < CntW'(WallSlots));
    end

    always_comb begin
        w_ctl          = '0;
        w_ctl.pos      = r_n;
        w_ctl.init     = w_accept && (i_in_item.command == CmdInit);
        w_ctl.app      = (r_state == ST_APP) && w_app_ok;
        w_ctl.app_addr = r_cnt[IdxW-1:0];
        w_ctl.app_data = pack_entry(w_ax, w_ay);
        w_ctl.shift    = (r_state == ST_ERASE);
    end

    mzg_list u_list (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .o_entry (w_entry)
    );

    mzg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && i_in_item.command == CmdStep && r_cnt != '0),
        .i_dividend (i_in_item.random_value),
        .i_divisor  (r_cnt),
        .o_busy     (w_mod_busy),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_t         <= '0;
            for (int i = 0; i < HalfCells; i++) begin
                for (int j = 0; j < HalfCells; j++) begin
                    r_vis[i][j]    <= 1'b0;
                    r_open_r[i][j] <= 1'b0;
                    r_open_d[i][j] <= 1'b0;
                end
            end
        end else begin
            // the finishing state loads the output register itself
            if (r_out_valid && !i_out_stall && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wall   <= (i_in_item.command == CmdRead) && w_rd_wall;
                        r_opened <= 1'b0;
                        r_state  <= (i_in_item.command == CmdStep && r_cnt != '0)
                                    ? ST_MOD : ST_FIN;
                        case (i_in_item.command)
                            CmdInit: begin
                                for (int i = 0; i < HalfCells; i++) begin
                                    for (int j = 0; j < HalfCells; j++) begin
                                        r_vis[i][j]    <= (i == 0) && (j == 0);
                                        r_open_r[i][j] <= 1'b0;
                                        r_open_d[i][j] <= 1'b0;
                                    end
                                end
                                r_cnt     <= CntW'(2);
                                r_started <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MOD: begin
                    if (!w_mod_busy) begin
                        r_n     <= w_mod_rem;
                        r_t     <= '0;
                        r_state <= ST_TREE;
                    end
                end
                ST_TREE: begin
                    r_t <= r_t + 2'd1;
                    if (r_t == 2'd3) begin
                        r_wx    <= w_entry[EntryW-1:CoordW];
                        r_wy    <= w_entry[CoordW-1:0];
                        r_side  <= 1'b0;
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (w_c_ok && !w_c_vis) begin
                        r_vis[w_cx6[HalfW:1]][w_cy6[HalfW:1]] <= 1'b1;
                        if (r_wx[0]) begin
                            r_open_d[w_oi][w_oj] <= 1'b1;
                        end else begin
                            r_open_r[w_oi][w_oj] <= 1'b1;
                        end
                        r_cx      <= w_cx6[CoordW-1:0];
                        r_cy      <= w_cy6[CoordW-1:0];
                        r_along_y <= r_wx[0];
                        r_opened  <= 1'b1;
                        r_t       <= '0;
                        r_state   <= ST_APP;
                    end else if (!r_side) begin
                        r_side <= 1'b1;
                    end else begin
                        r_state <= ST_ERASE;
                    end
                end
                ST_APP: begin
                    if (w_app_ok) begin
                        r_cnt <= r_cnt + CntW'(1);
                    end
                    r_t <= r_t + 2'd1;
                    if (r_t == 2'd2) begin
                        r_state <= ST_ERASE;
                    end
                end
                ST_ERASE: begin
                    r_cnt   <= r_cnt - CntW'(1);
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_item.cell_is_wall    <= r_wall;
                        r_out_item.wall_opened     <= r_opened;
                        r_out_item.walls_pending   <= PendW'(r_cnt);
                        r_out_item.maze_done       <= r_started && (r_cnt == '0);
                        r_state                    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- design/mzg_checker.sv -----
// ----------------------------------------------------------------------------
// mzg_checker
// Port-level checks on the maze generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_maze_generator_macros.svh"

module mzg_checker import mzg_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a finished maze has nothing left to try
    `MZG_ASSERT_IMPL(a_done_empty, o_out_valid && o_out_item.maze_done, o_out_item.walls_pending == '0)

    // a step that opens a wall is never a read
    `MZG_ASSERT_IMPL(a_open_not_wall, o_out_valid && o_out_item.wall_opened, !o_out_item.cell_is_wall)

    // hold a stalled item
    `MZG_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // drop any result on reset
    `MZG_ASSERT_RST(a_rst_clear, !i_rst_n, !o_out_valid)

endmodule

bind grid_maze_generator mzg_checker u_mzg_checker (.*);

// ----- bench/tb_grid_maze_generator.sv -----
// ----------------------------------------------------------------------------
// tb_grid_maze_generator
// Drives init, step and read items into the maze builder and checks every
// result against a cycle-free predictor of the grid, the visited map and the
// ordered candidate-wall list.
// ----------------------------------------------------------------------------
module tb_grid_maze_generator;
    import mzg_pkg::*;

    localparam logic [1:0] CmdNone   = 2'd3;
    localparam int         CellCount = GridSize * GridSize;
    localparam int         CycleCap  = 3000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    grid_maze_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    bit          maze_wall [CellCount];
    bit          maze_seen [CellCount];
    logic [9:0]  wall_list [WallSlots];
    int          wall_count;
    bit          maze_started;

    t_in_item    item_queue[$];
    t_out_item   expected_results[$];
    int          mismatch_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          stall_pct;

    function automatic int cell_at(int x, int y);
        return x * GridSize + y;
    endfunction

    function automatic void add_wall(int x, int y);
        if (x <= 0 || y <= 0 || x >= GridSize - 1 || y >= GridSize - 1) return;
        if (wall_count >= WallSlots) return;
        wall_list[wall_count] = {x[4:0], y[4:0]};
        wall_count++;
    endfunction

    function automatic bit enter_cell(int wx, int wy, int cx, int cy, bit along_y,
                                      bit fwd);
        if (cx < 0 || cy < 0 || cx >= GridSize || cy >= GridSize) return 1'b0;
        if (wx >= GridSize || wy >= GridSize) return 1'b0;
        if (maze_seen[cell_at(cx, cy)]) return 1'b0;
        maze_seen[cell_at(cx, cy)] = 1'b1;
        maze_wall[cell_at(wx, wy)] = 1'b0;
        if (along_y) begin
            add_wall(cx - 1, cy);
            add_wall(cx + 1, cy);
            add_wall(cx, fwd ? cy + 1 : cy - 1);
        end else begin
            add_wall(cx, cy - 1);
            add_wall(cx, cy + 1);
            add_wall(fwd ? cx + 1 : cx - 1, cy);
        end
        return 1'b1;
    endfunction

    function automatic void clear_maze();
        for (int x = 0; x < GridSize; x++)
            for (int y = 0; y < GridSize; y++)
                maze_wall[cell_at(x, y)] = (x % 2 == 0) || (y % 2 == 0);
        foreach (maze_seen[i]) maze_seen[i] = 1'b0;
    endfunction

    function automatic bit carve_step(int rnd);
        int  pick;
        int  wx;
        int  wy;
        bit  opened;
        opened = 1'b0;
        if (wall_count == 0) return 1'b0;
        pick = rnd % wall_count;
        wx = wall_list[pick][9:5];
        wy = wall_list[pick][4:0];
        if (wx % 2 == 1) begin
            if (wy >= 1) opened = enter_cell(wx, wy, wx, wy - 1, 1'b1, 1'b0);
            if (!opened) opened = enter_cell(wx, wy, wx, wy + 1, 1'b1, 1'b1);
        end else begin
            if (wx >= 1) opened = enter_cell(wx, wy, wx - 1, wy, 1'b0, 1'b0);
            if (!opened) opened = enter_cell(wx, wy, wx + 1, wy, 1'b0, 1'b1);
        end
        for (int i = pick; i + 1 < wall_count; i++) wall_list[i] = wall_list[i + 1];
        wall_count--;
        return opened;
    endfunction

    function automatic t_out_item predict_maze(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.command)
            CmdInit: begin
                clear_maze();
                maze_seen[cell_at(1, 1)] = 1'b1;
                wall_count = 0;
                add_wall(1, 2);
                add_wall(2, 1);
                maze_started = 1'b1;
            end
            CmdStep: r.wall_opened = carve_step(it.random_value);
            CmdRead: begin
                if (it.cell_x < GridSize && it.cell_y < GridSize)
                    r.cell_is_wall = maze_wall[cell_at(it.cell_x, it.cell_y)];
                else
                    r.cell_is_wall = 1'b1;
            end
            default: ;
        endcase
        r.walls_pending = wall_count[9:0];
        r.maze_done = maze_started && wall_count == 0;
        return r;
    endfunction

    function automatic void push_item(logic [1:0] cmd, int rnd, int x, int y);
        t_in_item it;
        it.command      = cmd;
        it.random_value = rnd[14:0];
        it.cell_x       = x[4:0];
        it.cell_y       = y[4:0];
        item_queue.insert(item_queue.size(), it);
    endfunction

    // driver: retire the accepted item, then present the head of the queue
    always @(posedge i_clk) begin
        bit accepted;
        accepted = i_rst_n && i_in_valid && !o_in_stall;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (accepted) begin
                expected_results.insert(expected_results.size(), predict_maze(i_in_item));
                void'(item_queue.pop_front());
            end
            if (!i_in_valid || accepted) begin
                if (item_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= item_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
        i_out_stall <= $urandom_range(99) < stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", o_out_item);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", want, o_out_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CycleCap) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        while (item_queue.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 3)       push_item(CmdInit, $urandom, $urandom, $urandom);
            else if (pick < 68) push_item(CmdStep, $urandom, $urandom, $urandom);
            else if (pick < 97)
                push_item(CmdRead, $urandom, $urandom_range(22), $urandom_range(22));
            else if (pick < 98)
                push_item(CmdRead, $urandom, $urandom_range(31), $urandom_range(31));
            else                push_item(CmdNone, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_in_item = '0;
        cycle_count = 0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        clear_maze();
        wall_count = 0;
        maze_started = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step and read before any init, unused command, edges of the fields
        push_item(CmdStep, 32767, 0, 0);
        push_item(CmdRead, 0, 0, 0);
        push_item(CmdRead, 0, 1, 1);
        push_item(CmdNone, 32767, 31, 31);
        push_item(CmdInit, 0, 0, 0);
        push_item(CmdStep, 0, 0, 0);
        push_item(CmdStep, 32767, 0, 0);
        push_item(CmdRead, 0, 1, 2);
        push_item(CmdRead, 0, 22, 22);
        push_item(CmdRead, 0, 23, 0);
        push_item(CmdRead, 0, 0, 23);
        push_item(CmdRead, 0, 31, 31);
        push_item(CmdRead, 21845, 21, 21);
        push_item(CmdRead, 10922, 10, 11);
        push_item(CmdInit, 32767, 31, 31);
        push_item(CmdStep, 1, 0, 0);
        push_item(CmdStep, 2, 0, 0);
        push_item(CmdInit, 0, 0, 0);
        push_item(CmdStep, 0, 0, 0);
        push_item(CmdStep, 0, 0, 0);
        push_item(CmdStep, 0, 0, 0);
        push_item(CmdStep, 0, 0, 0);
        drain();

        // idling phases: none, sender, receiver, both
        add_random(300);
        drain();
        sender_idle_pct = 87;
        add_random(300);
        drain();
        sender_idle_pct = 0;
        stall_pct = 87;
        add_random(300);
        drain();
        sender_idle_pct = 22;
        stall_pct = 22;
        add_random(450);
        drain();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
